// ===== sv/srw_pkg.sv =====
// srw_pkg: shared types and constants for the snapshot reader watermark block
// no dependencies; used by snapshot_reader_watermark
package srw_pkg;

	localparam int TABLE_DEPTH    = 64;
	localparam int REF_COUNT_BITS = 16;
	localparam int TIME_W         = 64;
	localparam int IDX_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OCC_W          = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W        = TIME_W + REF_COUNT_BITS;

	localparam logic [REF_COUNT_BITS-1:0] REF_MAX = '1;
	localparam logic [REF_COUNT_BITS-1:0] REF_ONE = REF_COUNT_BITS'(1);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_ALLOC  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_MISSING   = 2'd2,
		STS_SATURATED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

// ===== sv/srw_ram.sv =====
// srw_ram: generic single write port, single read port ram with registered read
// no dependencies
module srw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/snapshot_reader_watermark.sv =====
// snapshot_reader_watermark: reference-counted reader snapshot table with low watermark
// depends on srw_pkg and srw_ram
//
// the block holds up to TABLE_DEPTH distinct reader snapshot timestamps, each with a
// reference count, in one ram, plus a commit timestamp counter loaded by a write of
// initial_timestamp. an add or remove request walks the whole table through the ram's
// single read port, one entry per cycle, looking for the timestamp, the lowest free entry
// and the smallest other active timestamp; the update state then writes the entry and
// forms the result. allocate and the unused command need no walk and go straight to the
// update state. the smallest active timestamp is kept in a register, so allocate reports
// it without a walk. the block takes one request at a time: in_stall is high from accept
// until the result has been taken. status 1 flags a full table, 2 a remove of an unknown
// timestamp, 3 an add to a saturated count; none of these changes the table. write
// initial_timestamp only while the block is idle.
module snapshot_reader_watermark (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic [srw_pkg::TIME_W-1:0]          reader_time,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [srw_pkg::TIME_W-1:0]          low_watermark,
	output logic [6:0]                          retained_count,
	output logic [srw_pkg::TIME_W-1:0]          commit_time,
	output logic [1:0]                          status,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [srw_pkg::TIME_W-1:0]          initial_timestamp
);

	// sequencer
	srw_pkg::state_t state_q, state_d;

	// captured request
	srw_pkg::cmd_t                    cmd_q;
	logic [srw_pkg::TIME_W-1:0]       time_q;

	// table state
	logic [srw_pkg::TABLE_DEPTH-1:0]  valid_q;
	logic [srw_pkg::OCC_W-1:0]        occ_q;
	logic [srw_pkg::TIME_W-1:0]       commit_q;
	// smallest active timestamp of the table, kept between requests
	logic                             tmin_any_q;
	logic [srw_pkg::TIME_W-1:0]       tmin_q;

	// walk address and compare stage
	logic [srw_pkg::IDX_W-1:0]        cnt_q;
	logic                             cmp_vld_s1;
	logic [srw_pkg::IDX_W-1:0]        idx_s1;

	// walk results
	logic                             match_q;
	logic [srw_pkg::IDX_W-1:0]        match_idx_q;
	logic [srw_pkg::REF_COUNT_BITS-1:0] match_refs_q;
	logic                             free_q;
	logic [srw_pkg::IDX_W-1:0]        free_idx_q;
	logic                             xmin_any_q;
	logic [srw_pkg::TIME_W-1:0]       xmin_q;

	// result registers
	logic [srw_pkg::TIME_W-1:0]       lw_q;
	logic [srw_pkg::TIME_W-1:0]       ct_q;
	srw_pkg::status_t                 sts_q;

	// ram
	logic                             ram_we;
	logic [srw_pkg::IDX_W-1:0]        ram_waddr;
	logic [srw_pkg::ENTRY_W-1:0]      ram_wdata;
	logic [srw_pkg::ENTRY_W-1:0]      ram_rdata;
	logic [srw_pkg::TIME_W-1:0]       rd_time;
	logic [srw_pkg::REF_COUNT_BITS-1:0] rd_refs;

	// handshake decodes
	logic in_acc;
	logic cfg_acc;
	logic scan_last;
	logic walk_cmd;

	// update cycle decisions
	logic                             upd_set_valid;
	logic                             upd_clr_valid;
	logic                             upd_present;
	logic                             upd_occ_inc;
	logic                             upd_occ_dec;
	logic                             upd_alloc;
	srw_pkg::status_t                 upd_status;
	logic [srw_pkg::REF_COUNT_BITS-1:0] upd_refs;
	logic [srw_pkg::IDX_W-1:0]        upd_idx;
	logic                             new_any;
	logic [srw_pkg::TIME_W-1:0]       new_min;
	logic [srw_pkg::TIME_W-1:0]       new_commit;
	logic                             t_below;
	logic [srw_pkg::OCC_W+6:0]        occ_ext;

	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign scan_last = (cnt_q == srw_pkg::IDX_W'(srw_pkg::TABLE_DEPTH - 1));
	assign walk_cmd  = (srw_pkg::cmd_t'(command) == srw_pkg::CMD_ADD) ||
	                   (srw_pkg::cmd_t'(command) == srw_pkg::CMD_REMOVE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srw_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = walk_cmd ? srw_pkg::ST_SCAN : srw_pkg::ST_UPDATE;
				end
			end
			srw_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = srw_pkg::ST_DRAIN;
				end
			end
			srw_pkg::ST_DRAIN:  state_d = srw_pkg::ST_UPDATE;
			srw_pkg::ST_UPDATE: state_d = srw_pkg::ST_DONE;
			srw_pkg::ST_DONE: begin
				if (!out_stall) begin
					state_d = srw_pkg::ST_IDLE;
				end
			end
			default: state_d = srw_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			srw_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			srw_pkg::ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table memory: time in the upper bits, reference count in the lower
	srw_ram #(
		.WIDTH(srw_pkg::ENTRY_W),
		.DEPTH(srw_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	assign rd_time = ram_rdata[srw_pkg::ENTRY_W-1:srw_pkg::REF_COUNT_BITS];
	assign rd_refs = ram_rdata[srw_pkg::REF_COUNT_BITS-1:0];

	// walk address counter and compare stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == srw_pkg::ST_SCAN);
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == srw_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// capture request and fold one table entry per cycle into the walk results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			xmin_any_q <= 1'b0;
		end else if (in_acc) begin
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			xmin_any_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (valid_q[idx_s1]) begin
				if (rd_time == time_q) begin
					match_q <= 1'b1;
				end else if (!xmin_any_q || (rd_time < xmin_q)) begin
					xmin_any_q <= 1'b1;
				end
			end else begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= srw_pkg::cmd_t'(command);
			time_q <= reader_time;
		end else if (cmp_vld_s1) begin
			if (valid_q[idx_s1]) begin
				// timestamps are distinct in the table, so at most one hit
				if (rd_time == time_q) begin
					match_idx_q  <= idx_s1;
					match_refs_q <= rd_refs;
				end else if (!xmin_any_q || (rd_time < xmin_q)) begin
					xmin_q <= rd_time;
				end
			end else if (!free_q) begin
				// lowest numbered free entry
				free_idx_q <= idx_s1;
			end
		end
	end

	// update cycle decisions
	always_comb begin
		upd_set_valid = 1'b0;
		upd_clr_valid = 1'b0;
		upd_present   = 1'b0;
		upd_occ_inc   = 1'b0;
		upd_occ_dec   = 1'b0;
		upd_alloc     = 1'b0;
		upd_status    = srw_pkg::STS_OK;
		upd_refs      = srw_pkg::REF_ONE;
		upd_idx       = match_idx_q;
		ram_we        = 1'b0;
		unique case (cmd_q)
			srw_pkg::CMD_ADD: begin
				priority if (match_q) begin
					upd_present = 1'b1;
					if (match_refs_q == srw_pkg::REF_MAX) begin
						upd_status = srw_pkg::STS_SATURATED;
					end else begin
						upd_refs = match_refs_q + 1'b1;
						ram_we   = 1'b1;
					end
				end else if (free_q) begin
					upd_present   = 1'b1;
					upd_idx       = free_idx_q;
					upd_set_valid = 1'b1;
					upd_occ_inc   = 1'b1;
					ram_we        = 1'b1;
				end else begin
					upd_status = srw_pkg::STS_FULL;
				end
			end
			srw_pkg::CMD_REMOVE: begin
				priority if (!match_q) begin
					upd_status = srw_pkg::STS_MISSING;
				end else if (match_refs_q <= srw_pkg::REF_ONE) begin
					upd_clr_valid = 1'b1;
					upd_occ_dec   = (occ_q != '0);
				end else begin
					upd_present = 1'b1;
					upd_refs    = match_refs_q - 1'b1;
					ram_we      = 1'b1;
				end
			end
			srw_pkg::CMD_ALLOC: upd_alloc = 1'b1;
			srw_pkg::CMD_NOP:   ;
			default: ;
		endcase
		if (state_q != srw_pkg::ST_UPDATE) begin
			ram_we = 1'b0;
		end
	end

	assign ram_waddr = upd_idx;
	assign ram_wdata = {time_q, upd_refs};

	// new table minimum: smallest other entry, plus the request's timestamp if it stays
	assign t_below = !xmin_any_q || (time_q < xmin_q);

	always_comb begin
		new_any = tmin_any_q;
		new_min = tmin_q;
		if (cmd_q == srw_pkg::CMD_ADD || cmd_q == srw_pkg::CMD_REMOVE) begin
			new_any = xmin_any_q || upd_present;
			new_min = (upd_present && t_below) ? time_q : xmin_q;
		end
	end

	assign new_commit = upd_alloc ? (commit_q + 1'b1) : commit_q;

	// table control state, commit counter and cached minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			occ_q      <= '0;
			commit_q   <= '0;
			tmin_any_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				commit_q <= initial_timestamp;
			end else if (state_q == srw_pkg::ST_UPDATE) begin
				commit_q <= new_commit;
			end
			if (state_q == srw_pkg::ST_UPDATE) begin
				tmin_any_q <= new_any;
				if (upd_set_valid) begin
					valid_q[upd_idx] <= 1'b1;
				end
				if (upd_clr_valid) begin
					valid_q[upd_idx] <= 1'b0;
				end
				if (upd_occ_inc) begin
					occ_q <= occ_q + 1'b1;
				end else if (upd_occ_dec) begin
					occ_q <= occ_q - 1'b1;
				end
			end
		end
	end

	// result payload, held while the result waits
	always_ff @(posedge clk) begin
		if (state_q == srw_pkg::ST_UPDATE) begin
			tmin_q <= new_min;
			lw_q   <= new_any ? new_min : new_commit;
			ct_q   <= new_commit;
			sts_q  <= upd_status;
		end
	end

	// occupancy is current once the update has landed; wide tables report low bits
	assign occ_ext        = {7'd0, occ_q};
	assign retained_count = occ_ext[6:0];
	assign low_watermark  = lw_q;
	assign commit_time    = ct_q;
	assign status         = sts_q;

	// occupancy tracks the number of valid entries
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy differs from valid entry count");

	// no new request while a result is pending
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	// the update cycle always presents a result next
	a_update_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srw_pkg::ST_UPDATE) |=> out_valid)
		else $error("update not followed by result");

	// the walk covers the whole table before the update
	a_walk_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srw_pkg::ST_DRAIN) |-> $past(scan_last))
		else $error("walk ended early");

endmodule
